/* hw/rtl/ahmb_pkg.sv */
// Shared constants, request codes and controller/datapath interface types.
package ahmb_pkg;

    localparam int BINS_PER_AXIS = 16;
    localparam int MAX_POINTS    = 64;
    localparam int ANGLE_PI      = 25736;
    localparam int ANGLE_TWO_PI  = 51472;

    localparam int BIN_TOTAL = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int AXIS_W    = $clog2(BINS_PER_AXIS);
    localparam int BIN_W     = $clog2(BIN_TOTAL);
    localparam int PT_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W     = 7;
    localparam int COUNT_MAX = 127;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef struct packed {
        logic accept;      // transaction taken this cycle
        logic cnt_rd_old;  // read count of the point's previous bin
        logic dec_old;     // write back decremented count, unbind point
        logic cnt_rd_new;  // read count of the new bin
        logic inc_new;     // write back incremented count, bind point
        logic scan_rd;     // read next bin count during mode search
        logic pts_rd;      // read next point binding during id walk
        logic emit_empty;  // emit the empty-histogram answer
    } t_cmd;

    typedef struct packed {
        logic id_ok;       // point id on the input is within range
        logic ins_new;     // latched add carries a valid point
        logic scan_last;   // final bin address is being read
        logic best_zero;   // mode search found no point
        logic emit_last;   // final id of the run is latched this cycle
    } t_status;

endpackage

/* hw/rtl/ahmb_quant.sv */
// Angle pair to bin index quantizer (threshold compare per grid line).
module ahmb_quant (
    input  logic [14:0]                  i_angle_x,
    input  logic signed [15:0]           i_angle_y,
    output logic [ahmb_pkg::BIN_W-1:0]   o_bin
);

    localparam int NX_W = 15 + ahmb_pkg::AXIS_W;
    localparam int NY_W = 16 + ahmb_pkg::AXIS_W;

    logic [NX_W-1:0]             num_x;
    logic [NY_W-1:0]             num_y;
    logic [16:0]                 shifted;
    logic                        y_pos;
    logic [ahmb_pkg::AXIS_W-1:0] xq;
    logic [ahmb_pkg::AXIS_W-1:0] yq;

    assign num_x   = NX_W'(i_angle_x) * NX_W'(ahmb_pkg::BINS_PER_AXIS - 1);
    assign shifted = {i_angle_y[15], i_angle_y} + 17'(ahmb_pkg::ANGLE_PI);
    assign y_pos   = !shifted[16] && (shifted != 17'd0);
    assign num_y   = NY_W'(shifted[15:0]) * NY_W'(ahmb_pkg::BINS_PER_AXIS - 1);

    // floor(num/den) saturated to N-1: highest grid line not above num; yq = 0 if xq = 0 or y + PI <= 0
    always_comb begin
        xq = '0;
        yq = '0;
        for (int k = 1; k < ahmb_pkg::BINS_PER_AXIS; k++) begin
            if (num_x >= NX_W'(k * ahmb_pkg::ANGLE_PI)) begin
                xq = ahmb_pkg::AXIS_W'(k);
            end
            if (num_y >= NY_W'(k * ahmb_pkg::ANGLE_TWO_PI)) begin
                yq = ahmb_pkg::AXIS_W'(k);
            end
        end
        if (xq == '0 || !y_pos) begin
            yq = '0;
        end
    end

    assign o_bin = ahmb_pkg::BIN_W'(yq) * ahmb_pkg::BIN_W'(ahmb_pkg::BINS_PER_AXIS)
                 + ahmb_pkg::BIN_W'(xq);

endmodule

/* hw/rtl/ahmb_ctrl.sv */
// Sequencer for update, mode search and id walk.
module ahmb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_req_type,
    input  ahmb_pkg::t_status   i_status,
    output ahmb_pkg::t_cmd      o_cmd,
    output logic                o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_U_OLD,
        S_U_DEC,
        S_U_RDNEW,
        S_U_INC,
        S_Q_SCAN,
        S_Q_DRAIN,
        S_Q_DECIDE,
        S_Q_PTS
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start) begin
                    unique case (ahmb_pkg::t_req'(i_req_type))
                        ahmb_pkg::REQ_CLEAR:  n_state = S_IDLE;
                        ahmb_pkg::REQ_ADD,
                        ahmb_pkg::REQ_REMOVE: n_state = i_status.id_ok ? S_U_OLD : S_IDLE;
                        ahmb_pkg::REQ_QUERY:  n_state = S_Q_SCAN;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_U_OLD: begin
                o_cmd.cnt_rd_old = 1'b1;
                n_state = S_U_DEC;
            end
            S_U_DEC: begin
                o_cmd.dec_old = 1'b1;
                n_state = i_status.ins_new ? S_U_RDNEW : S_IDLE;
            end
            S_U_RDNEW: begin
                o_cmd.cnt_rd_new = 1'b1;
                n_state = S_U_INC;
            end
            S_U_INC: begin
                o_cmd.inc_new = 1'b1;
                n_state = S_IDLE;
            end
            S_Q_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_Q_DRAIN;
                end
            end
            S_Q_DRAIN: begin
                n_state = S_Q_DECIDE;
            end
            S_Q_DECIDE: begin
                o_cmd.emit_empty = i_status.best_zero;
                n_state = i_status.best_zero ? S_IDLE : S_Q_PTS;
            end
            S_Q_PTS: begin
                o_cmd.pts_rd = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hw/rtl/ahmb_dp.sv */
// Datapath: bin count memory, point binding memory, mode search, result registers.
module ahmb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ahmb_pkg::t_cmd      i_cmd,
    output ahmb_pkg::t_status   o_status,
    input  logic [1:0]          i_req_type,
    input  logic [5:0]          i_point_id,
    input  logic [14:0]         i_angle_x,
    input  logic signed [15:0]  i_angle_y,
    input  logic                i_point_valid,
    output logic                o_strobe,
    output logic [5:0]          o_found_point_id,
    output logic [7:0]          o_mode_bin,
    output logic [6:0]          o_mode_count,
    output logic                o_found,
    output logic                o_last
);

    localparam int BW = ahmb_pkg::BIN_W;
    localparam int PW = ahmb_pkg::PT_W;
    localparam int CW = ahmb_pkg::CNT_W;

    // storage
    logic [CW-1:0] r_cnt_mem [ahmb_pkg::BIN_TOTAL];
    logic [BW-1:0] r_pb_mem  [ahmb_pkg::MAX_POINTS];
    logic [ahmb_pkg::BIN_TOTAL-1:0]  r_cnt_vld;
    logic [ahmb_pkg::MAX_POINTS-1:0] r_bound;

    // latched transaction
    ahmb_pkg::t_req     r_req;
    logic [PW-1:0]      r_id;
    logic [14:0]        r_ax;
    logic signed [15:0] r_ay;
    logic               r_valid;

    logic [BW-1:0] r_new_bin;
    logic [BW-1:0] r_old_bin;
    logic          r_old_bound;
    logic [BW-1:0] q_bin;

    // memory read side
    logic [CW-1:0] r_cnt_rdata;
    logic          r_cnt_rvld;
    logic [BW-1:0] r_pb_rdata;
    logic          r_pb_rbound;
    logic [BW-1:0] cnt_raddr;
    logic          cnt_ren;
    logic [PW-1:0] pb_raddr;
    logic          pb_ren;
    logic [CW-1:0] cnt_eff;
    logic          cnt_we;
    logic [BW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;

    // search and walk
    logic [BW-1:0] r_idx;
    logic [BW-1:0] r_idx_d;
    logic          r_scan_pend;
    logic [BW-1:0] r_best;
    logic [CW-1:0] r_bestc;
    logic [PW-1:0] r_pidx;
    logic [PW-1:0] r_pidx_d;
    logic          r_pts_pend;
    logic [CW-1:0] r_emit_cnt;
    logic          emit_hit;
    logic          emit_is_last;

    // result registers
    logic          r_strobe;
    logic [5:0]    r_found_id;
    logic [7:0]    r_mode_bin;
    logic [6:0]    r_mode_count;
    logic          r_found;
    logic          r_last;

    ahmb_quant u_quant (
        .i_angle_x (r_ax),
        .i_angle_y (r_ay),
        .o_bin     (q_bin)
    );

    assign cnt_eff = r_cnt_rvld ? r_cnt_rdata : '0;

    always_comb begin
        priority if (i_cmd.cnt_rd_old) begin
            cnt_raddr = r_pb_rdata;
        end else if (i_cmd.cnt_rd_new) begin
            cnt_raddr = r_new_bin;
        end else begin
            cnt_raddr = r_idx;
        end
    end
    assign cnt_ren = i_cmd.cnt_rd_old | i_cmd.cnt_rd_new | i_cmd.scan_rd;

    assign pb_raddr = i_cmd.accept ? PW'(i_point_id) : r_pidx;
    assign pb_ren   = i_cmd.accept | i_cmd.pts_rd;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_old_bin;
        cnt_wdata = (cnt_eff != '0) ? cnt_eff - CW'(1) : '0;
        if (i_cmd.dec_old && r_old_bound) begin
            cnt_we = 1'b1;
        end else if (i_cmd.inc_new) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_new_bin;
            cnt_wdata = (cnt_eff < CW'(ahmb_pkg::COUNT_MAX)) ? cnt_eff + CW'(1) : cnt_eff;
        end
    end

    // count memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_ren) begin
            r_cnt_rdata <= r_cnt_mem[cnt_raddr];
        end
    end

    // binding memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.inc_new) begin
            r_pb_mem[r_id] <= r_new_bin;
        end
        if (pb_ren) begin
            r_pb_rdata <= r_pb_mem[pb_raddr];
        end
    end

    assign emit_hit = r_pts_pend && r_pb_rbound && (r_pb_rdata == r_best)
                   && (r_emit_cnt != r_bestc);
    // each bound point is counted once, so the mode count is the run length
    assign emit_is_last = ((r_emit_cnt + CW'(1)) == r_bestc);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld   <= '0;
            r_bound     <= '0;
            r_scan_pend <= 1'b0;
            r_pts_pend  <= 1'b0;
            r_strobe    <= 1'b0;
            r_cnt_rvld  <= 1'b0;
            r_pb_rbound <= 1'b0;
        end else begin
            r_scan_pend <= i_cmd.scan_rd;
            r_pts_pend  <= i_cmd.pts_rd;
            r_strobe    <= i_cmd.emit_empty | emit_hit;
            if (cnt_ren) begin
                r_cnt_rvld <= r_cnt_vld[cnt_raddr];
            end
            if (i_cmd.pts_rd) begin
                r_pb_rbound <= r_bound[r_pidx];
            end
            if (i_cmd.accept && ahmb_pkg::t_req'(i_req_type) == ahmb_pkg::REQ_CLEAR) begin
                r_cnt_vld <= '0;
                r_bound   <= '0;
            end else begin
                if (cnt_we) begin
                    r_cnt_vld[cnt_waddr] <= 1'b1;
                end
                if (i_cmd.dec_old) begin
                    r_bound[r_id] <= 1'b0;
                end else if (i_cmd.inc_new) begin
                    r_bound[r_id] <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req      <= ahmb_pkg::t_req'(i_req_type);
            r_id       <= PW'(i_point_id);
            r_ax       <= i_angle_x;
            r_ay       <= i_angle_y;
            r_valid    <= i_point_valid;
            r_idx      <= '0;
            r_best     <= '0;
            r_bestc    <= '0;
            r_pidx     <= '0;
            r_emit_cnt <= '0;
        end
        if (i_cmd.cnt_rd_old) begin
            r_new_bin   <= q_bin;
            r_old_bin   <= r_pb_rdata;
            r_old_bound <= r_bound[r_id];
        end
        if (i_cmd.scan_rd) begin
            r_idx   <= r_idx + BW'(1);
            r_idx_d <= r_idx;
        end
        if (r_scan_pend && cnt_eff > r_bestc) begin
            r_best  <= r_idx_d;
            r_bestc <= cnt_eff;
        end
        if (i_cmd.pts_rd) begin
            r_pidx_d <= r_pidx;
            if (r_pidx != PW'(ahmb_pkg::MAX_POINTS - 1)) begin
                r_pidx <= r_pidx + PW'(1);
            end
        end
        if (emit_hit) begin
            r_emit_cnt   <= r_emit_cnt + CW'(1);
            r_found_id   <= 6'(r_pidx_d);
            r_mode_bin   <= 8'(r_best);
            r_mode_count <= r_bestc;
            r_found      <= 1'b1;
            r_last       <= emit_is_last;
        end else if (i_cmd.emit_empty) begin
            r_found_id   <= '0;
            r_mode_bin   <= '0;
            r_mode_count <= '0;
            r_found      <= 1'b0;
            r_last       <= 1'b1;
        end
    end

    assign o_status.id_ok     = ({1'b0, i_point_id} < 7'(ahmb_pkg::MAX_POINTS));
    assign o_status.ins_new   = (r_req == ahmb_pkg::REQ_ADD) && r_valid;
    assign o_status.scan_last = (r_idx == BW'(ahmb_pkg::BIN_TOTAL - 1));
    assign o_status.best_zero = (r_bestc == '0);
    assign o_status.emit_last = emit_hit && emit_is_last;

    assign o_strobe         = r_strobe;
    assign o_found_point_id = r_found_id;
    assign o_mode_bin       = r_mode_bin;
    assign o_mode_count     = r_mode_count;
    assign o_found          = r_found;
    assign o_last           = r_last;

endmodule

/* hw/rtl/angle_histogram_mode_bin.sv */
// Top level: 2-D angle bin histogram with most-frequent-bin query.
// A transaction is taken when start is high and busy is low. Clear leaves busy
// low. Remove, and add with the valid flag low, read the point's binding and
// its old bin's counter, then write back the decremented counter if the point
// was bound; an add of a valid point also reads and writes back the counter of
// its new bin. Each counter update is a read-modify-write through the read and
// write ports of the bin count memory. A query reads every bin counter through
// that same read port, then, unless the histogram is empty, walks the point
// binding memory up to the run's last result. Results appear one per cycle or
// with gaps on o_strobe, each for a single cycle, and cannot be held off by the
// receiver; o_last marks the end of a query's run. An empty histogram answers
// with one result with o_found low. Reset clears both stores at once.
module angle_histogram_mode_bin (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic [5:0]          i_point_id,
    input  logic [14:0]         i_angle_x,
    input  logic signed [15:0]  i_angle_y,
    input  logic                i_point_valid,
    output logic                o_strobe,
    output logic [5:0]          o_found_point_id,
    output logic [7:0]          o_mode_bin,
    output logic [6:0]          o_mode_count,
    output logic                o_found,
    output logic                o_last
);

    ahmb_pkg::t_cmd    cmd;
    ahmb_pkg::t_status status;

    ahmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    ahmb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req_type),
        .i_point_id       (i_point_id),
        .i_angle_x        (i_angle_x),
        .i_angle_y        (i_angle_y),
        .i_point_valid    (i_point_valid),
        .o_strobe         (o_strobe),
        .o_found_point_id (o_found_point_id),
        .o_mode_bin       (o_mode_bin),
        .o_mode_count     (o_mode_count),
        .o_found          (o_found),
        .o_last           (o_last)
    );

endmodule
